// ----- design/fpfl_pkg.sv -----
// ----------------------------------------------------------------------------
// Free list allocator package
// Shared constants, codes and types of the fixed pool free list allocator.
// ----------------------------------------------------------------------------
package fpfl_pkg;

    // Built depth of the pool.
    localparam int POOL_DEPTH = 64;
    // The pool never uses more than 64 entries, whatever the built depth.
    localparam int POOL_LIMIT = (POOL_DEPTH < 64) ? POOL_DEPTH : 64;
    // Address width of the entry stores.
    localparam int ADDR_W     = $clog2(POOL_LIMIT);

    // Field widths of the items.
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int STATUS_W   = 2;

    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(POOL_LIMIT);
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // Request kinds.
    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_DOUBLE    = 2'd2,
        STATUS_BEYOND    = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Write request to the in-use mark store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              val;
    } mark_wr_t;

endpackage

// ----- design/fpfl_mark_store.sv -----
// ----------------------------------------------------------------------------
// In-use mark store
// One-bit-wide entry memory with a registered read and a valid bit per entry,
// so that a clear makes every entry read as free at once.
// ----------------------------------------------------------------------------
module fpfl_mark_store
    import fpfl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data,
    input  mark_wr_t          wr
);

    logic                  mark_mem [POOL_LIMIT];
    logic [POOL_LIMIT-1:0] vld_reg;
    logic                  rd_mem_reg;
    logic                  rd_vld_reg;

    // Memory write port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mark_mem[wr.addr] <= wr.val;
        end
    end

    // Registered read of the mark and of its valid bit.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_mem_reg <= mark_mem[rd_addr];
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // An entry becomes valid when first written; a clear drops them all.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // An entry never written since the last clear reads as free.
    assign rd_data = rd_mem_reg & rd_vld_reg;

endmodule

// ----- design/fixed_pool_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// Fixed pool free list allocator
// Hands out and takes back entries of a fixed pool through a LIFO free list.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries requests: s_tuser is the operation (0 allocate,
//   1 release) and s_tdata holds the index to release. The m_ channel returns
//   one result item per request: the status in m_tuser, the granted index and
//   the live count in m_tdata.
//   The acceptance edge reads the link memory at the stack head and the mark
//   store at the release index; the commit edge, once the output register is
//   free, loads it and on success updates the marks and, for a release, the
//   link memory. No new request is taken until the last one has committed.
//   A request is accepted while an earlier result still waits in the output
//   register; it is then held until that result is taken, so a stalled
//   receiver stops the block after one request.
//   Reset, and every write of cfg_wdata, return the pool to a state with every
//   entry free and never used; no clearing pass is needed, so the block takes
//   requests in the first cycle after reset. After reset the capacity is 64.
//   Users must write configuration only while no request is in flight; unenforced.
// ----------------------------------------------------------------------------
module fixed_pool_free_list_allocator
    import fpfl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: capacity.
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // Requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] release_index, [7:6] zero
    input  logic [0:0]  s_tuser,   // [0] operation
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] granted_index, [12:6] live_count
    output logic [1:0]  m_tuser    // [1:0] status
);

    state_t             state_reg, state_next;
    logic               op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   capacity_reg;
    logic [IDX_W-1:0]   head_reg;
    logic               nonempty_reg;
    logic [CNT_W-1:0]   fresh_reg;
    logic [CNT_W-1:0]   alloc_reg;
    logic [IDX_W-1:0]   link_rd_reg;
    logic [IDX_W-1:0]   link_mem [POOL_LIMIT];

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [IDX_W-1:0]   out_grant_reg;
    logic [CNT_W-1:0]   out_live_reg;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic               mark_rd;
    mark_wr_t           mark_wr;
    logic [CNT_W-1:0]   cap_eff;
    logic [CNT_W-1:0]   alloc_inc;
    logic               pop_ok;
    logic               fresh_ok;

    status_t            status_c;
    logic [IDX_W-1:0]   grant_c;
    logic [IDX_W-1:0]   head_c;
    logic               nonempty_c;
    logic [CNT_W-1:0]   fresh_c;
    logic [CNT_W-1:0]   alloc_c;
    logic               link_we_c;

    // Handshake terms.
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign commit   = (state_reg == S_EXEC) && out_free;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_EXEC:  s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture of the request.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tuser[0];
            idx_reg <= s_tdata[IDX_W-1:0];
        end
    end

    // Link memory: read at the stack head on acceptance, written on release.
    always_ff @(posedge aclk) begin
        if (accept) begin
            link_rd_reg <= link_mem[head_reg[ADDR_W-1:0]];
        end
        if (commit && link_we_c) begin
            link_mem[idx_reg[ADDR_W-1:0]] <= head_reg;
        end
    end

    // The capacity in force, clamped to the built depth.
    assign cap_eff   = (capacity_reg > CAP_MAX) ? CAP_MAX : capacity_reg;
    assign alloc_inc = alloc_reg + CNT_W'(1);
    assign pop_ok    = nonempty_reg && ({1'b0, head_reg} < cap_eff);
    assign fresh_ok  = fresh_reg < cap_eff;

    // Request evaluation with the read data of both memories.
    always_comb begin
        status_c      = STATUS_OK;
        grant_c       = '0;
        head_c        = head_reg;
        nonempty_c    = nonempty_reg;
        fresh_c       = fresh_reg;
        alloc_c       = alloc_reg;
        link_we_c     = 1'b0;
        mark_wr.en    = 1'b0;
        mark_wr.addr  = idx_reg[ADDR_W-1:0];
        mark_wr.val   = 1'b0;
        if (op_reg == OP_ALLOC) begin
            priority if (pop_ok) begin
                // Pop the most recently released entry.
                grant_c      = head_reg;
                head_c       = link_rd_reg;
                alloc_c      = alloc_inc;
                nonempty_c   = fresh_reg > alloc_inc;
                mark_wr.en   = 1'b1;
                mark_wr.addr = head_reg[ADDR_W-1:0];
                mark_wr.val  = 1'b1;
            end else if (fresh_ok) begin
                // Hand out the next never-used entry.
                grant_c      = fresh_reg[IDX_W-1:0];
                fresh_c      = fresh_reg + CNT_W'(1);
                alloc_c      = alloc_inc;
                mark_wr.en   = 1'b1;
                mark_wr.addr = fresh_reg[ADDR_W-1:0];
                mark_wr.val  = 1'b1;
            end else begin
                status_c = STATUS_EXHAUSTED;
            end
        end else begin
            priority if ({1'b0, idx_reg} >= cap_eff) begin
                status_c = STATUS_BEYOND;
            end else if (!mark_rd) begin
                status_c = STATUS_DOUBLE;
            end else begin
                // Push the entry onto the released stack.
                head_c       = idx_reg;
                nonempty_c   = 1'b1;
                alloc_c      = alloc_reg - CNT_W'(1);
                link_we_c    = 1'b1;
                mark_wr.en   = 1'b1;
                mark_wr.val  = 1'b0;
            end
        end
        if (!commit) begin
            mark_wr.en = 1'b0;
        end
    end

    // In-use marks, read at the release index on acceptance.
    fpfl_mark_store u_marks (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_we),
        .rd_en   (accept),
        .rd_addr (s_tdata[ADDR_W-1:0]),
        .rd_data (mark_rd),
        .wr      (mark_wr)
    );

    // Pool state registers; a capacity write restarts the pool.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            fresh_reg    <= '0;
            alloc_reg    <= '0;
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            fresh_reg    <= '0;
            alloc_reg    <= '0;
        end else if (commit) begin
            head_reg     <= head_c;
            nonempty_reg <= nonempty_c;
            fresh_reg    <= fresh_c;
            alloc_reg    <= alloc_c;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_status_reg <= status_c;
            out_grant_reg  <= grant_c;
            out_live_reg   <= alloc_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_live_reg, out_grant_reg};

endmodule
